[rtl/stc_pkg.sv]
// Shared constants, types and helper functions of the stereo corner triangulator.
package stc_pkg;

	localparam int CORNERS_PER_TAG = 4;
	localparam int PIXEL_FRAC_BITS = 4;

	localparam int PIX_W    = 16;
	localparam int COORD_W  = 32;
	localparam int CNT_W    = (CORNERS_PER_TAG > 1) ? $clog2(CORNERS_PER_TAG) : 1;
	localparam int ZMAG_W   = COORD_W + PIXEL_FRAC_BITS;
	localparam int PROD_W   = PIX_W + ZMAG_W;
	localparam int DIV_W    = PROD_W + (PROD_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int NUM_REGS  = 5;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int REG_DATA_W = COORD_W;

	localparam logic [REG_IDX_W-1:0] REG_FOCAL_X        = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y        = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X       = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y       = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_BASELINE_FOCAL = REG_IDX_W'(4);

	localparam logic [PIX_W-1:0]   FOCAL_X_RST        = PIX_W'(8000);
	localparam logic [PIX_W-1:0]   FOCAL_Y_RST        = PIX_W'(8000);
	localparam logic [PIX_W-1:0]   CENTER_X_RST       = PIX_W'(5120);
	localparam logic [PIX_W-1:0]   CENTER_Y_RST       = PIX_W'(3840);
	localparam logic [COORD_W-1:0] BASELINE_FOCAL_RST = COORD_W'(3276800);

	localparam logic [COORD_W-1:0] S32_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] S32_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [PIX_W-1:0]   focal_x;
		logic [PIX_W-1:0]   focal_y;
		logic [PIX_W-1:0]   center_x;
		logic [PIX_W-1:0]   center_y;
		logic [COORD_W-1:0] baseline_focal;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// magnitude of a 17 bit signed difference of two pixel values
	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W:0] d);
		logic [PIX_W:0] n;
		n = -d;
		return d[PIX_W] ? n[PIX_W-1:0] : d[PIX_W-1:0];
	endfunction

	// sign and magnitude to saturated signed 32 bit
	function automatic logic [COORD_W-1:0] sat32(input logic neg,
		input logic [DIV_W-1:0] mag);
		logic [COORD_W-1:0] low;
		low = mag[COORD_W-1:0];
		if (!neg) begin
			return (mag > DIV_W'(S32_MAX)) ? S32_MAX : low;
		end
		return (mag > DIV_W'(S32_MIN)) ? S32_MIN : COORD_W'(-low);
	endfunction

endpackage

[rtl/stc_if.sv]
// Handshake interfaces for corner input and point output transfers.
interface stc_corner_if;
	logic                        valid;
	logic                        ready;
	logic [stc_pkg::PIX_W-1:0] u_left;
	logic [stc_pkg::PIX_W-1:0] v_left;
	logic [stc_pkg::PIX_W-1:0] u_right;

	modport source (output valid, u_left, v_left, u_right, input ready);
	modport sink (input valid, u_left, v_left, u_right, output ready);
endinterface

interface stc_point_if;
	logic                               valid;
	logic                               ready;
	logic signed [stc_pkg::COORD_W-1:0] x_meters;
	logic signed [stc_pkg::COORD_W-1:0] y_meters;
	logic signed [stc_pkg::COORD_W-1:0] z_meters;
	logic                               last_point;

	modport source (output valid, x_meters, y_meters, z_meters, last_point, input ready);
	modport sink (input valid, x_meters, y_meters, z_meters, last_point, output ready);
endinterface

[rtl/stc_cfg.sv]
// Configuration register file: camera intrinsics and baseline-focal product.
module stc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [stc_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [stc_pkg::REG_DATA_W-1:0]    wr_data,
	output stc_pkg::cfg_t                      cfg
);

	stc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x        <= stc_pkg::FOCAL_X_RST;
			cfg_q.focal_y        <= stc_pkg::FOCAL_Y_RST;
			cfg_q.center_x       <= stc_pkg::CENTER_X_RST;
			cfg_q.center_y       <= stc_pkg::CENTER_Y_RST;
			cfg_q.baseline_focal <= stc_pkg::BASELINE_FOCAL_RST;
		end else if (wr_en) begin
			case (wr_index)
				stc_pkg::REG_FOCAL_X: begin
					cfg_q.focal_x <= wr_data[stc_pkg::PIX_W-1:0];
				end
				stc_pkg::REG_FOCAL_Y: begin
					cfg_q.focal_y <= wr_data[stc_pkg::PIX_W-1:0];
				end
				stc_pkg::REG_CENTER_X: begin
					cfg_q.center_x <= wr_data[stc_pkg::PIX_W-1:0];
				end
				stc_pkg::REG_CENTER_Y: begin
					cfg_q.center_y <= wr_data[stc_pkg::PIX_W-1:0];
				end
				stc_pkg::REG_BASELINE_FOCAL: begin
					cfg_q.baseline_focal <= wr_data[stc_pkg::COORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/stc_div.sv]
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module stc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [stc_pkg::DIV_W-1:0]       dividend,
	input  logic [stc_pkg::PIX_W-1:0]       divisor,
	output logic [stc_pkg::DIV_W-1:0]       quotient,
	output stc_pkg::div_stat_t               stat
);

	localparam int W = stc_pkg::PIX_W;

	logic                              busy_q;
	logic                              done_q;
	logic [stc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [W-1:0]                      rem_q;
	logic [W-1:0]                      dvs_q;
	logic [stc_pkg::DIV_W-1:0]        quo_q;

	logic [W:0]   r1;
	logic [W:0]   r2;
	logic [W-1:0] ra;
	logic [W-1:0] rb;
	logic         ge1;
	logic         ge2;

	always_comb begin
		r1  = {rem_q, quo_q[stc_pkg::DIV_W-1]};
		ge1 = r1 >= {1'b0, dvs_q};
		ra  = ge1 ? W'(r1 - {1'b0, dvs_q}) : r1[W-1:0];
		r2  = {ra, quo_q[stc_pkg::DIV_W-2]};
		ge2 = r2 >= {1'b0, dvs_q};
		rb  = ge2 ? W'(r2 - {1'b0, dvs_q}) : r2[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == stc_pkg::DIV_CNT_W'(stc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[stc_pkg::DIV_W-3:0], ge1, ge2};
			rem_q <= rb;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/stereo_corner_triangulator.sv]
// Stereo corner triangulator: disparity, depth and lateral position per corner.
// Each corner makes three passes through the shared 2-bit-per-cycle divider (depth,
// then x, then y); a zero-disparity corner skips the divider and is marked invalid.
// A new corner is taken only once the current one is done. After the last corner of
// a tag, 4 point transfers follow before the next corner, unless any corner was invalid.
// Reset clears the corner count and invalid mark and loads register defaults.
module stereo_corner_triangulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [stc_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [stc_pkg::REG_DATA_W-1:0]   wr_data,
	stc_corner_if.sink                        corner_in,
	stc_point_if.source                       point_out
);

	localparam int CW = stc_pkg::COORD_W;
	localparam int PW = stc_pkg::PIX_W;
	localparam int NC = stc_pkg::CORNERS_PER_TAG;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_ZDIV = 10'b0000000010,
		S_MULX = 10'b0000000100,
		S_LDX  = 10'b0000001000,
		S_DIVX = 10'b0000010000,
		S_MULY = 10'b0000100000,
		S_LDY  = 10'b0001000000,
		S_DIVY = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t state_q;

	stc_pkg::cfg_t     cfg;
	stc_pkg::div_stat_t div_stat;

	logic [stc_pkg::CNT_W-1:0]   count_q;
	logic [stc_pkg::CNT_W-1:0]   emit_q;
	logic                        invalid_q;

	logic [PW-1:0]               dx_mag_q;
	logic                        dx_neg_q;
	logic [PW-1:0]               dy_mag_q;
	logic                        dy_neg_q;
	logic [stc_pkg::ZMAG_W-1:0]  z_mag_q;
	logic                        z_neg_q;
	logic [stc_pkg::PROD_W-1:0]  prod_q;

	logic signed [CW-1:0] held_x_q [NC];
	logic signed [CW-1:0] held_y_q [NC];
	logic signed [CW-1:0] held_z_q [NC];

	logic                        in_xfer;
	logic                        out_xfer;
	logic [PW:0]                 disp;
	logic [PW:0]                 diff_x;
	logic [PW:0]                 diff_y;
	logic [CW-1:0]               bf_neg_val;
	logic [CW-1:0]               bf_mag;
	logic                        div_start;
	logic [stc_pkg::DIV_W-1:0]   div_dividend;
	logic [PW-1:0]               div_divisor;
	logic [stc_pkg::DIV_W-1:0]   quotient;
	logic [stc_pkg::DIV_W-1:0]   xy_mag;
	logic [PW-1:0]               mul_a;
	logic                        last_slot;

	stc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign in_xfer  = corner_in.valid && corner_in.ready;
	assign out_xfer = point_out.valid && point_out.ready;

	assign disp   = {1'b0, corner_in.u_left} - {1'b0, corner_in.u_right};
	assign diff_x = {1'b0, corner_in.u_left} - {1'b0, cfg.center_x};
	assign diff_y = {1'b0, corner_in.v_left} - {1'b0, cfg.center_y};

	assign bf_neg_val = -cfg.baseline_focal;
	assign bf_mag     = cfg.baseline_focal[CW-1] ? bf_neg_val : cfg.baseline_focal;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = stc_pkg::DIV_W'(bf_mag) << stc_pkg::PIXEL_FRAC_BITS;
		div_divisor  = stc_pkg::abs_diff(disp);
		case (state_q)
			S_IDLE: begin
				div_start = in_xfer && (disp != '0);
			end
			S_LDX: begin
				div_start    = 1'b1;
				div_dividend = stc_pkg::DIV_W'(prod_q);
				div_divisor  = cfg.focal_x;
			end
			S_LDY: begin
				div_start    = 1'b1;
				div_dividend = stc_pkg::DIV_W'(prod_q);
				div_divisor  = cfg.focal_y;
			end
			default: begin
			end
		endcase
	end

	stc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// zero numerator gives zero even when the focal length is zero
	assign xy_mag    = (prod_q == '0) ? '0 : quotient;
	assign mul_a     = (state_q == S_MULY) ? dy_mag_q : dx_mag_q;
	assign last_slot = count_q == stc_pkg::CNT_W'(NC - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			emit_q    <= '0;
			invalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (disp == '0) begin
							invalid_q <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_ZDIV;
						end
					end
				end
				S_ZDIV: begin
					if (div_stat.done) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: begin
					state_q <= S_LDX;
				end
				S_LDX: begin
					state_q <= S_DIVX;
				end
				S_DIVX: begin
					if (div_stat.done) begin
						state_q <= S_MULY;
					end
				end
				S_MULY: begin
					state_q <= S_LDY;
				end
				S_LDY: begin
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (last_slot) begin
						count_q   <= '0;
						invalid_q <= 1'b0;
						emit_q    <= '0;
						state_q   <= invalid_q ? S_IDLE : S_EMIT;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_xfer) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == stc_pkg::CNT_W'(NC - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dx_mag_q <= stc_pkg::abs_diff(diff_x);
			dx_neg_q <= diff_x[PW];
			dy_mag_q <= stc_pkg::abs_diff(diff_y);
			dy_neg_q <= diff_y[PW];
			z_neg_q  <= cfg.baseline_focal[CW-1] ^ disp[PW];
			if (disp == '0) begin
				held_x_q[count_q] <= '0;
				held_y_q[count_q] <= '0;
				held_z_q[count_q] <= '0;
			end
		end
		if (state_q == S_ZDIV && div_stat.done) begin
			z_mag_q <= quotient[stc_pkg::ZMAG_W-1:0];
		end
		if (state_q == S_MULX || state_q == S_MULY) begin
			prod_q <= stc_pkg::PROD_W'(mul_a) * stc_pkg::PROD_W'(z_mag_q);
		end
		if (state_q == S_DIVX && div_stat.done) begin
			held_x_q[count_q] <= stc_pkg::sat32(dx_neg_q ^ z_neg_q, xy_mag);
		end
		if (state_q == S_DIVY && div_stat.done) begin
			held_y_q[count_q] <= stc_pkg::sat32(dy_neg_q ^ z_neg_q, xy_mag);
			held_z_q[count_q] <= stc_pkg::sat32(z_neg_q, stc_pkg::DIV_W'(z_mag_q));
		end
	end

	assign corner_in.ready     = state_q == S_IDLE;
	assign point_out.valid     = state_q == S_EMIT;
	assign point_out.x_meters  = held_x_q[emit_q];
	assign point_out.y_meters  = held_y_q[emit_q];
	assign point_out.z_meters  = held_z_q[emit_q];
	assign point_out.last_point = emit_q == stc_pkg::CNT_W'(NC - 1);

	a_no_input_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		point_out.valid |-> !corner_in.ready)
		else $error("corner input open while points are being sent");

	a_busy_after_corner: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !corner_in.ready)
		else $error("corner input open right after a corner transfer");

	a_last_ends_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && point_out.last_point |=> !point_out.valid)
		else $error("point output still valid after the last point of a tag");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

endmodule
